FILE: rtl/assert_macros.svh
// Assertion macros shared by the reflection vector RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RVU_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("reflection vector unit assertion failed");
`define RVU_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define RVU_ASSERT(label, prop)
`define RVU_ASSERT_MSG(label, prop, msg)
`endif
`endif

FILE: rtl/rvu_pkg.sv
// Types and fixed constants of the reflection vector unit.
// Used by every module of the block; depends on nothing.
`default_nettype none
package rvu_pkg;

    localparam int COMP_W    = 16;
    localparam int NORM_BITS = 30;
    localparam int SUM_W     = 2 * NORM_BITS + 2;
    localparam int ROOT_W    = NORM_BITS + 1;

    typedef struct packed {
        logic signed [COMP_W-1:0] incident_x;
        logic signed [COMP_W-1:0] incident_y;
        logic signed [COMP_W-1:0] incident_z;
        logic signed [COMP_W-1:0] normal_x;
        logic signed [COMP_W-1:0] normal_y;
        logic signed [COMP_W-1:0] normal_z;
    } rvu_in_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] reflected_x;
        logic signed [COMP_W-1:0] reflected_y;
        logic signed [COMP_W-1:0] reflected_z;
        logic                     degenerate;
    } rvu_out_t;

    typedef struct packed {
        logic                            degenerate;
        logic [2:0]                      neg;
        logic [2:0][NORM_BITS-1:0]       a;
    } rvu_side_t;

endpackage
`default_nettype wire

FILE: rtl/reflection_vector_unit.sv
// Top level of the reflection vector unit: front pipeline, square root, divider lanes.
// Depends on rvu_pkg, rvu_front, rvu_sqrt, rvu_div and assert_macros.svh.
//
//   channel  | beat                  | handshake
//   pair     | incident L, normal N  | pair_valid / pair_stall
//   refl     | unit R, degenerate    | refl_valid / refl_stall
//
// One beat is accepted per cycle while no result beat waits on refl_stall. The square
// root resolves one root bit per stage and the divider one quotient bit per stage.
// Reset clears only the valid bits of the stages.
// The whole pipeline holds while a result beat waits on refl_stall; pair_stall follows.
`default_nettype none
`include "assert_macros.svh"
module reflection_vector_unit #(
    parameter int FRACTION_BITS = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pair_valid,
    output logic              pair_stall,
    input  rvu_pkg::rvu_in_t  pair,
    output logic              refl_valid,
    input  logic              refl_stall,
    output rvu_pkg::rvu_out_t refl
);
    logic                        en;
    logic                        front_valid;
    rvu_pkg::rvu_side_t          front_side;
    logic [rvu_pkg::SUM_W-1:0]   front_sum;
    logic                        root_valid;
    rvu_pkg::rvu_side_t          root_side;
    logic [rvu_pkg::ROOT_W-1:0]  root;

    assign en         = !(refl_valid && refl_stall);
    assign pair_stall = !en;

    rvu_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pair_valid),
        .in_data   (pair),
        .out_valid (front_valid),
        .out_side  (front_side),
        .out_sum   (front_sum)
    );

    rvu_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_side   (front_side),
        .in_sum    (front_sum),
        .out_valid (root_valid),
        .out_side  (root_side),
        .out_root  (root)
    );

    rvu_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (root_valid),
        .in_side   (root_side),
        .in_root   (root),
        .out_valid (refl_valid),
        .out_data  (refl)
    );

    `RVU_ASSERT(a_degenerate_zero, refl_valid && refl.degenerate |->
                refl.reflected_x == '0 && refl.reflected_y == '0 && refl.reflected_z == '0)
    `RVU_ASSERT_MSG(a_stall_cause, pair_stall |-> refl_valid && refl_stall,
                    "input stalled without a waiting result")
    `RVU_ASSERT(a_root_live, root_valid && !root_side.degenerate |-> root != '0)
endmodule
`default_nettype wire

FILE: rtl/rvu_front.sv
// Front pipeline: dot product, reflected vector, magnitudes, range shift, sum of squares.
// Depends on rvu_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rvu_front #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  rvu_pkg::rvu_in_t            in_data,
    output logic                        out_valid,
    output rvu_pkg::rvu_side_t          out_side,
    output logic [rvu_pkg::SUM_W-1:0]   out_sum
);
    localparam int W   = rvu_pkg::COMP_W;
    localparam int PW  = 2 * W;
    localparam int CPW = 2 * W + 2;
    localparam int NW  = 3 * W + 2;
    localparam int VF  = (3 * W + 3 > W + 2 * FRACTION_BITS + 2) ? 3 * W + 3
                                                              : W + 2 * FRACTION_BITS + 2;
    localparam int VW  = (VF > 64) ? 64 : VF;
    localparam int NB  = rvu_pkg::NORM_BITS;
    localparam int SB  = (VW > NB + 1) ? $clog2(VW - NB) : 1;

    logic signed [W-1:0]   l_in [3];
    logic signed [W-1:0]   n_in [3];

    logic                  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v7_reg, v8_reg;
    logic signed [W-1:0]   l1_reg [3];
    logic signed [W-1:0]   n1_reg [3];
    logic signed [PW-1:0]  p1_reg [3];
    logic signed [W-1:0]   l2_reg [3];
    logic signed [W-1:0]   n2_reg [3];
    logic signed [CPW-1:0] c2_reg;
    logic signed [W-1:0]   l3_reg [3];
    logic signed [NW-1:0]  nc3_reg [3];
    logic signed [VW-1:0]  vec4_reg [3];
    logic [VW-1:0]         mag5_reg [3];
    logic [2:0]            neg5_reg;
    logic                  zero5_reg;

    logic [VW-1:0]         sh_mag_reg [SB+1][3];
    logic [VW-1:0]         sh_max_reg [SB+1];
    logic [2:0]            sh_neg_reg [SB+1];
    logic                  sh_zero_reg [SB+1];
    logic                  sh_valid_reg [SB+1];

    logic [NB-1:0]         a7_reg [3];
    logic [2:0]            neg7_reg;
    logic                  zero7_reg;
    logic [2*NB-1:0]       sq8_reg [3];
    logic [NB-1:0]         a8_reg [3];
    logic [2:0]            neg8_reg;
    logic                  zero8_reg;

    logic                      out_valid_reg;
    rvu_pkg::rvu_side_t        side_reg;
    logic [rvu_pkg::SUM_W-1:0] sum_reg;

    logic [VW-1:0]         max_next;
    logic                  top_shift;

    always_comb
    begin
        l_in[0] = in_data.incident_x;
        l_in[1] = in_data.incident_y;
        l_in[2] = in_data.incident_z;
        n_in[0] = in_data.normal_x;
        n_in[1] = in_data.normal_y;
        n_in[2] = in_data.normal_z;
        max_next = (mag5_reg[0] > mag5_reg[1]) ? mag5_reg[0] : mag5_reg[1];
        if (mag5_reg[2] > max_next)
        begin
            max_next = mag5_reg[2];
        end
        top_shift = (sh_max_reg[SB] >> NB) != '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            v5_reg          <= 1'b0;
            sh_valid_reg[0] <= 1'b0;
            v7_reg          <= 1'b0;
            v8_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            v1_reg          <= in_valid;
            v2_reg          <= v1_reg;
            v3_reg          <= v2_reg;
            v4_reg          <= v3_reg;
            v5_reg          <= v4_reg;
            sh_valid_reg[0] <= v5_reg;
            v7_reg          <= sh_valid_reg[SB];
            v8_reg          <= v7_reg;
            out_valid_reg   <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                l1_reg[i]  <= l_in[i];
                n1_reg[i]  <= n_in[i];
                p1_reg[i]  <= l_in[i] * n_in[i];
                l2_reg[i]  <= l1_reg[i];
                n2_reg[i]  <= n1_reg[i];
                l3_reg[i]  <= l2_reg[i];
                nc3_reg[i] <= n2_reg[i] * c2_reg;
                vec4_reg[i] <= (VW'(nc3_reg[i]) <<< 1)
                             - (VW'(l3_reg[i]) <<< (2 * FRACTION_BITS));
                mag5_reg[i] <= vec4_reg[i][VW-1] ? VW'(-vec4_reg[i]) : VW'(vec4_reg[i]);
                neg5_reg[i] <= vec4_reg[i][VW-1];
                sh_mag_reg[0][i] <= mag5_reg[i];
                a7_reg[i]  <= top_shift ? NB'(sh_mag_reg[SB][i] >> 1)
                                        : NB'(sh_mag_reg[SB][i]);
                sq8_reg[i] <= a7_reg[i] * a7_reg[i];
                a8_reg[i]  <= a7_reg[i];
                side_reg.a[i] <= a8_reg[i];
            end
            c2_reg <= CPW'(p1_reg[0]) + CPW'(p1_reg[1]) + CPW'(p1_reg[2]);
            zero5_reg <= (vec4_reg[0] == '0) && (vec4_reg[1] == '0) && (vec4_reg[2] == '0);
            sh_max_reg[0]  <= max_next;
            sh_neg_reg[0]  <= neg5_reg;
            sh_zero_reg[0] <= zero5_reg;
            neg7_reg  <= sh_neg_reg[SB];
            zero7_reg <= sh_zero_reg[SB];
            neg8_reg  <= neg7_reg;
            zero8_reg <= zero7_reg;
            side_reg.neg        <= neg8_reg;
            side_reg.degenerate <= zero8_reg;
            sum_reg <= rvu_pkg::SUM_W'(sq8_reg[0]) + rvu_pkg::SUM_W'(sq8_reg[1])
                     + rvu_pkg::SUM_W'(sq8_reg[2]);
        end
    end

    for (genvar j = 1; j <= SB; j++)
    begin : g_shift
        localparam int AMT = 1 << (SB - j);
        logic take;
        assign take = (sh_max_reg[j-1] >> (AMT + NB)) != '0;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sh_valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                sh_valid_reg[j] <= sh_valid_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sh_mag_reg[j][i] <= take ? (sh_mag_reg[j-1][i] >> AMT) : sh_mag_reg[j-1][i];
                end
                sh_max_reg[j]  <= take ? (sh_max_reg[j-1] >> AMT) : sh_max_reg[j-1];
                sh_neg_reg[j]  <= sh_neg_reg[j-1];
                sh_zero_reg[j] <= sh_zero_reg[j-1];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_side  = side_reg;
    assign out_sum   = sum_reg;

    `RVU_ASSERT(a_zero_sum, out_valid_reg && side_reg.degenerate |-> sum_reg == '0)
    `RVU_ASSERT_MSG(a_live_sum, out_valid_reg && !side_reg.degenerate |-> sum_reg != '0,
                    "nonzero reflection produced a zero sum of squares")
    `RVU_ASSERT(a_hold_front, out_valid_reg && !en |=> $stable(sum_reg) && out_valid_reg)
endmodule
`default_nettype wire

FILE: rtl/rvu_sqrt.sv
// Pipelined integer square root, one root bit per stage, side data carried along.
// Depends on rvu_pkg.
`default_nettype none
module rvu_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  rvu_pkg::rvu_side_t          in_side,
    input  logic [rvu_pkg::SUM_W-1:0]   in_sum,
    output logic                        out_valid,
    output rvu_pkg::rvu_side_t          out_side,
    output logic [rvu_pkg::ROOT_W-1:0]  out_root
);
    localparam int NS = rvu_pkg::ROOT_W;
    localparam int SW = rvu_pkg::SUM_W;

    logic [SW-1:0]      rem_reg [NS];
    logic [SW-1:0]      res_reg [NS];
    logic               valid_reg [NS];
    rvu_pkg::rvu_side_t side_reg [NS];

    for (genvar j = 0; j < NS; j++)
    begin : g_stage
        localparam logic [SW-1:0] BIT = SW'(1) << (2 * (NS - 1 - j));
        logic [SW-1:0]      rem_in;
        logic [SW-1:0]      res_in;
        logic               valid_in;
        rvu_pkg::rvu_side_t side_in;
        logic [SW-1:0]      trial;
        logic [SW-1:0]      rem_next;
        logic [SW-1:0]      res_next;

        if (j == 0)
        begin : g_first
            assign rem_in   = in_sum;
            assign res_in   = '0;
            assign valid_in = in_valid;
            assign side_in  = in_side;
        end
        else
        begin : g_rest
            assign rem_in   = rem_reg[j-1];
            assign res_in   = res_reg[j-1];
            assign valid_in = valid_reg[j-1];
            assign side_in  = side_reg[j-1];
        end

        always_comb
        begin
            trial = res_in + BIT;
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                res_reg[j]  <= res_next;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign out_root  = res_reg[NS-1][NS-1:0];
endmodule
`default_nettype wire

FILE: rtl/rvu_div.sv
// Three-lane pipelined restoring divider with rounding, sign and degenerate handling.
// Depends on rvu_pkg.
`default_nettype none
module rvu_div #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  rvu_pkg::rvu_side_t          in_side,
    input  logic [rvu_pkg::ROOT_W-1:0]  in_root,
    output logic                        out_valid,
    output rvu_pkg::rvu_out_t           out_data
);
    localparam int W  = rvu_pkg::COMP_W;
    localparam int LW = rvu_pkg::ROOT_W;
    localparam int CW = LW + FRACTION_BITS + 1;
    localparam int QW = FRACTION_BITS + 1;

    logic [CW-1:0]      rem_reg [QW+1][3];
    logic [QW-1:0]      q_reg [QW+1][3];
    logic [LW-1:0]      len_reg [QW+1];
    rvu_pkg::rvu_side_t side_reg [QW+1];
    logic               valid_reg [QW+1];

    logic               out_valid_reg;
    rvu_pkg::rvu_out_t  out_reg;
    logic [LW-1:0]      len_in;
    logic [W-1:0]       comp [3];

    always_comb
    begin
        len_in = (in_root == '0) ? LW'(1) : in_root;
        for (int i = 0; i < 3; i++)
        begin
            comp[i] = W'(q_reg[QW][i]);
            if (side_reg[QW].degenerate)
            begin
                comp[i] = '0;
            end
            else if (side_reg[QW].neg[i])
            begin
                comp[i] = ~comp[i] + W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0]  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0]  <= in_valid;
            out_valid_reg <= valid_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= (CW'(in_side.a[i]) << FRACTION_BITS) + CW'(len_in >> 1);
                q_reg[0][i]   <= '0;
            end
            len_reg[0]  <= len_in;
            side_reg[0] <= in_side;
            out_reg.reflected_x <= comp[0];
            out_reg.reflected_y <= comp[1];
            out_reg.reflected_z <= comp[2];
            out_reg.degenerate  <= side_reg[QW].degenerate;
        end
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_bit
        localparam int K = QW - j;
        logic [CW-1:0] divs;
        assign divs = CW'(len_reg[j-1]) << K;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= valid_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_reg[j-1][i] >= divs)
                    begin
                        rem_reg[j][i] <= rem_reg[j-1][i] - divs;
                        q_reg[j][i]   <= q_reg[j-1][i] | (QW'(1) << K);
                    end
                    else
                    begin
                        rem_reg[j][i] <= rem_reg[j-1][i];
                        q_reg[j][i]   <= q_reg[j-1][i];
                    end
                end
                len_reg[j]  <= len_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for reflection_vector_unit: random and directed beats of L and N.
// Depends on rvu_pkg; a scoreboard class predicts each unit reflected vector exactly.
`default_nettype none
module tb;

    class refl_scoreboard;
        rvu_pkg::rvu_out_t pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function bit [63:0] widen(logic [rvu_pkg::COMP_W-1:0] x);
            return {{(64-rvu_pkg::COMP_W){x[rvu_pkg::COMP_W-1]}}, x};
        endfunction

        function bit [63:0] root_floor(bit [63:0] n);
            bit [63:0] res;
            bit [63:0] b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n)
                b = b >> 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function rvu_pkg::rvu_out_t reflect(rvu_pkg::rvu_in_t p);
            bit [63:0] l[3];
            bit [63:0] n[3];
            bit [63:0] v[3];
            bit [63:0] m[3];
            bit [63:0] a[3];
            bit [63:0] c, maxm, sum, len, q;
            int s;
            rvu_pkg::rvu_out_t r;
            l[0] = widen(p.incident_x);
            l[1] = widen(p.incident_y);
            l[2] = widen(p.incident_z);
            n[0] = widen(p.normal_x);
            n[1] = widen(p.normal_y);
            n[2] = widen(p.normal_z);
            c = l[0] * n[0] + l[1] * n[1] + l[2] * n[2];
            for (int i = 0; i < 3; i++)
                v[i] = 64'd2 * n[i] * c - (l[i] << 28);
            r = '0;
            if (v[0] == 0 && v[1] == 0 && v[2] == 0)
            begin
                r.degenerate = 1'b1;
                return r;
            end
            maxm = 0;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = v[i][63] ? (64'd0 - v[i]) : v[i];
                if (m[i] > maxm)
                    maxm = m[i];
            end
            s = 0;
            while ((maxm >> s) >= (64'd1 << rvu_pkg::NORM_BITS))
                s++;
            sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                a[i] = m[i] >> s;
                sum = sum + a[i] * a[i];
            end
            len = root_floor(sum);
            if (len == 0)
                len = 1;
            for (int i = 0; i < 3; i++)
            begin
                q = ((a[i] << 14) + (len >> 1)) / len;
                if (v[i][63])
                    q = 64'd0 - q;
                if (i == 0) r.reflected_x = q[rvu_pkg::COMP_W-1:0];
                if (i == 1) r.reflected_y = q[rvu_pkg::COMP_W-1:0];
                if (i == 2) r.reflected_z = q[rvu_pkg::COMP_W-1:0];
            end
            return r;
        endfunction

        task report(string what, int got, int want);
            $display("tb: mismatch on %s: got %0d, want %0d", what, got, want);
            errors++;
        endtask

        function void note_pair(rvu_pkg::rvu_in_t p);
            pending.push_back(reflect(p));
        endfunction

        task check_refl(rvu_pkg::rvu_out_t r);
            rvu_pkg::rvu_out_t e;
            if (pending.size() == 0)
            begin
                report("unexpected beat", 1, 0);
                return;
            end
            e = pending.pop_front();
            if (r.reflected_x !== e.reflected_x)
                report("reflected_x", r.reflected_x, e.reflected_x);
            if (r.reflected_y !== e.reflected_y)
                report("reflected_y", r.reflected_y, e.reflected_y);
            if (r.reflected_z !== e.reflected_z)
                report("reflected_z", r.reflected_z, e.reflected_z);
            if (r.degenerate !== e.degenerate)
                report("degenerate", r.degenerate, e.degenerate);
        endtask
    endclass

    localparam int N_DIRECTED = 20;
    localparam int N_TOTAL    = N_DIRECTED + 1950;
    localparam int LIMIT      = 200000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              pair_valid = 1'b0;
    logic              pair_stall;
    rvu_pkg::rvu_in_t  pair = '0;
    logic              refl_valid;
    logic              refl_stall = 1'b0;
    rvu_pkg::rvu_out_t refl;

    refl_scoreboard    sb = new();
    rvu_pkg::rvu_in_t  directed[N_DIRECTED];
    int                sent = 0;
    int                got = 0;
    int                cycles = 0;

    reflection_vector_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_stall (pair_stall),
        .pair       (pair),
        .refl_valid (refl_valid),
        .refl_stall (refl_stall),
        .refl       (refl)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function logic [15:0] rand_comp(int kind);
        logic [15:0] x;
        case (kind)
            0: x = 16'($urandom);
            1: x = 16'($urandom_range(0, 32767)) - 16'd16384;
            2: x = 16'($urandom_range(0, 7)) - 16'd4;
            default: x = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
        endcase
        return x;
    endfunction

    function rvu_pkg::rvu_in_t rand_pair();
        rvu_pkg::rvu_in_t p;
        int kind;
        kind = $urandom_range(0, 9);
        kind = (kind < 5) ? 0 : (kind < 8) ? 1 : (kind < 9) ? 2 : 3;
        p.incident_x = rand_comp(kind);
        p.incident_y = rand_comp(kind);
        p.incident_z = rand_comp(kind);
        p.normal_x = rand_comp(kind);
        p.normal_y = rand_comp(kind);
        p.normal_z = rand_comp(kind);
        if ($urandom_range(0, 39) == 0)
        begin
            p.incident_x = '0;
            p.incident_y = '0;
            p.incident_z = '0;
        end
        return p;
    endfunction

    function bit quiet(int idx);
        return idx >= 900 && idx < 1250;
    endfunction

    initial
    begin
        directed[0]  = '0;
        directed[1]  = {16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h7fff};
        directed[2]  = {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
        directed[3]  = {16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
        directed[4]  = {16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000};
        directed[5]  = {16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000};
        directed[6]  = {16'h0000, 16'hc000, 16'h0000, 16'h0000, 16'h4000, 16'h0000};
        directed[7]  = {16'h2d41, 16'hd2bf, 16'h0000, 16'h0000, 16'h4000, 16'h0000};
        directed[8]  = {16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
        directed[9]  = {16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h0000};
        directed[10] = {16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001};
        directed[11] = {16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h4000};
        directed[12] = {16'h8000, 16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000};
        directed[13] = {16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 16'h0fed, 16'hcba9};
        directed[14] = {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
        directed[15] = {16'h0000, 16'h4000, 16'h0000, 16'h2d41, 16'h2d41, 16'h0000};
        directed[16] = {16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
        directed[17] = {16'h0000, 16'h0000, 16'h0001, 16'h8000, 16'h8000, 16'h8000};
        directed[18] = {16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555};
        directed[19] = {16'h0002, 16'hfffe, 16'h0003, 16'h0000, 16'h0001, 16'h0000};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (sent == N_TOTAL);
        wait (got == N_TOTAL);
        repeat (150) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        int idx;
        idx = sent;
        if (rst_n)
        begin
            if (pair_valid && !pair_stall)
            begin
                sb.note_pair(pair);
                idx = sent + 1;
                sent <= idx;
            end
            if (!pair_valid || !pair_stall)
            begin
                if (idx >= N_TOTAL || (!quiet(idx) && $urandom_range(0, 99) < 23))
                    pair_valid <= 1'b0;
                else
                begin
                    pair_valid <= 1'b1;
                    pair <= (idx < N_DIRECTED) ? directed[idx] : rand_pair();
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (refl_valid && !refl_stall)
            begin
                sb.check_refl(refl);
                got <= got + 1;
            end
            refl_stall <= !quiet(got) && $urandom_range(0, 99) < 23;
        end
    end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/rvu_pkg.sv
rtl/rvu_front.sv
rtl/rvu_sqrt.sv
rtl/rvu_div.sv
rtl/reflection_vector_unit.sv
verif/tb.sv
